[rtl/core/ntt_2x2_butterfly_mod_q_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the 2x2 NTT butterfly block.
// Both macros expect signals named clk and rst in the module that uses them.
// ----------------------------------------------------------------------------
`ifndef NTT_2X2_BUTTERFLY_MOD_Q_ASSERT_SVH
`define NTT_2X2_BUTTERFLY_MOD_Q_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NTT2_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NTT2_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/ntt2_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt2_pkg
// Constants, types and modular arithmetic helpers for the 2x2 NTT butterfly.
// The modulus is q = 2^23 - 2^13 + 1, which lets products be folded with
// shifts and adds instead of a general reduction.
// ----------------------------------------------------------------------------
package ntt2_pkg;

  localparam int unsigned COEFF_W     = 23;
  localparam int unsigned PROD_W      = 2 * COEFF_W;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned BFLY_STAGES = 6;
  localparam int unsigned NUM_STAGES  = 1 + 2 * BFLY_STAGES;

  localparam logic [COEFF_W-1:0] MODULUS = 23'd8380417;
  localparam logic [COEFF_W-1:0] HALF_UP = 23'd4190209;

  // Configuration register word index (paddr[2]).
  localparam logic REG_MODE = 1'b0;

  localparam logic [1:0] MODE_FWD  = 2'd0;
  localparam logic [1:0] MODE_INV  = 2'd1;
  localparam logic [1:0] MODE_MUL  = 2'd2;
  localparam logic [1:0] MODE_PASS = 2'd3;

  typedef enum logic [1:0] {
    OP_FWD,
    OP_INV,
    OP_PASS
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [BFLY_STAGES-1:0] en;
  } bfly_ctrl_t;

  // Single conditional subtract; any 23-bit value is below 2q.
  function automatic logic [COEFF_W-1:0] red_in(input logic [COEFF_W-1:0] v);
    return (v >= MODULUS) ? (v - MODULUS) : v;
  endfunction

  function automatic logic [COEFF_W-1:0] add_mod(input logic [COEFF_W-1:0] x,
                                                 input logic [COEFF_W-1:0] y);
    logic [COEFF_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    return (s >= {1'b0, MODULUS}) ? COEFF_W'(s - {1'b0, MODULUS}) : s[COEFF_W-1:0];
  endfunction

  function automatic logic [COEFF_W-1:0] sub_mod(input logic [COEFF_W-1:0] x,
                                                 input logic [COEFF_W-1:0] y);
    logic [COEFF_W:0] s;
    s = {1'b0, x} + {1'b0, MODULUS} - {1'b0, y};
    return (x >= y) ? (x - y) : s[COEFF_W-1:0];
  endfunction

  // Multiplication by the inverse of two.
  function automatic logic [COEFF_W-1:0] halve(input logic [COEFF_W-1:0] v);
    logic [COEFF_W-1:0] h;
    h = {1'b0, v[COEFF_W-1:1]};
    return v[0] ? (h + HALF_UP) : h;
  endfunction

  // 2^23 is congruent to 2^13 - 1, so each fold replaces the high part hi
  // by hi * 2^13 - hi.
  function automatic logic [36:0] fold_hi(input logic [PROD_W-1:0] p);
    return {14'b0, p[22:0]} + {1'b0, p[45:23], 13'b0} - {14'b0, p[45:23]};
  endfunction

  function automatic logic [27:0] fold_mid(input logic [36:0] v);
    return {5'b0, v[22:0]} + {1'b0, v[36:23], 13'b0} - {14'b0, v[36:23]};
  endfunction

  function automatic logic [COEFF_W-1:0] fold_lo(input logic [27:0] w);
    logic [COEFF_W:0] u;
    u = {1'b0, w[22:0]} + {6'b0, w[27:23], 13'b0} - {19'b0, w[27:23]};
    return (u >= {1'b0, MODULUS}) ? COEFF_W'(u - {1'b0, MODULUS}) : u[COEFF_W-1:0];
  endfunction

endpackage

[rtl/core/ntt2_bfly.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntt2_bfly
// Six-stage pipelined radix-2 butterfly with a built-in multiply mod q.
// Stages: pre-add, multiply, three reduction folds, post-add.
// ----------------------------------------------------------------------------
module ntt2_bfly
  import ntt2_pkg::*;
(
  input  logic               clk,
  input  bfly_ctrl_t         ctrl,
  input  logic [COEFF_W-1:0] x,
  input  logic [COEFF_W-1:0] y,
  input  logic [COEFF_W-1:0] t,
  output logic [COEFF_W-1:0] x_res,
  output logic [COEFF_W-1:0] y_res
);

  logic [COEFF_W-1:0] x_pre, m_pre, t_pre;
  logic [COEFF_W-1:0] x_mul, x_f1, x_f2, x_f3;
  logic [PROD_W-1:0]  prod;
  logic [36:0]        f1;
  logic [27:0]        f2;
  logic [COEFF_W-1:0] pm;
  logic [PROD_W-1:0]  prod_c;

  assign prod_c = {{COEFF_W{1'b0}}, t_pre} * {{COEFF_W{1'b0}}, m_pre};

  always_ff @(posedge clk) begin
    // In inverse mode the sum is halved here and the difference is what
    // gets multiplied by the twiddle.
    if (ctrl.en[0]) begin
      t_pre <= t;
      if (ctrl.op == OP_INV) begin
        x_pre <= halve(add_mod(x, y));
        m_pre <= sub_mod(x, y);
      end else begin
        x_pre <= x;
        m_pre <= y;
      end
    end
    if (ctrl.en[1]) begin
      prod  <= prod_c;
      x_mul <= x_pre;
    end
    if (ctrl.en[2]) begin
      f1   <= fold_hi(prod);
      x_f1 <= x_mul;
    end
    if (ctrl.en[3]) begin
      f2   <= fold_mid(f1);
      x_f2 <= x_f1;
    end
    if (ctrl.en[4]) begin
      pm   <= fold_lo(f2);
      x_f3 <= x_f2;
    end
    if (ctrl.en[5]) begin
      case (ctrl.op)
        OP_FWD: begin
          x_res <= add_mod(x_f3, pm);
          y_res <= sub_mod(x_f3, pm);
        end
        OP_INV: begin
          x_res <= x_f3;
          y_res <= halve(pm);
        end
        default: begin
          x_res <= x_f3;
          y_res <= pm;
        end
      endcase
    end
  end

endmodule

[rtl/core/ntt_2x2_butterfly_mod_q.sv]
`timescale 1ns / 1ps
// Throughput: one item per cycle unless the result stalls. Each pipeline
// stage holds one item and moves on whenever the stage after it is free,
// so bubbles close up. A stalled result does not hold back the input until
// all stages are full. Reset clears every stage valid bit and sets the
// mode to forward NTT.
// ----------------------------------------------------------------------------
// ntt_2x2_butterfly_mod_q
// Two radix-2 butterfly stages mod q over four coefficients, with forward,
// inverse, pointwise multiply and pass modes and an APB mode register.
// ----------------------------------------------------------------------------
`include "ntt_2x2_butterfly_mod_q_assert.svh"

module ntt_2x2_butterfly_mod_q
  import ntt2_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // coefficient channel
  input  logic               coeff_valid,
  output logic               coeff_stall,
  input  logic [COEFF_W-1:0] coeff_a,
  input  logic [COEFF_W-1:0] coeff_b,
  input  logic [COEFF_W-1:0] coeff_c,
  input  logic [COEFF_W-1:0] coeff_d,
  input  logic [COEFF_W-1:0] twiddle_1,
  input  logic [COEFF_W-1:0] twiddle_2,
  input  logic [COEFF_W-1:0] twiddle_3,
  input  logic [COEFF_W-1:0] twiddle_4,
  // result channel
  output logic               result_valid,
  input  logic               result_stall,
  output logic [COEFF_W-1:0] out_a,
  output logic [COEFF_W-1:0] out_b,
  output logic [COEFF_W-1:0] out_c,
  output logic [COEFF_W-1:0] out_d,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  logic [1:0]            mode;
  op_t                   op;
  logic [NUM_STAGES-1:0] stage_valid, stage_valid_next;
  logic [NUM_STAGES-1:0] ready;

  logic [COEFF_W-1:0] a_r, b_r, c_r, d_r, t1_r, t2_r, t3_r, t4_r;
  logic [COEFF_W-1:0] tw3_dly [BFLY_STAGES];
  logic [COEFF_W-1:0] tw4_dly [BFLY_STAGES];

  logic [COEFF_W-1:0] x1_in, y1_in, x2_in, y2_in;
  logic [COEFF_W-1:0] x1_res, y1_res, x2_res, y2_res;
  logic [COEFF_W-1:0] x3_in, y3_in, x4_in, y4_in;
  logic [COEFF_W-1:0] x3_res, y3_res, x4_res, y4_res;
  bfly_ctrl_t         ctrl1, ctrl2;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_FWD;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MODE)) begin
      mode <= pwdata[1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MODE) begin
      prdata = {{(DATA_W-2){1'b0}}, mode};
    end
  end

  always_comb begin
    case (mode)
      MODE_FWD: op = OP_FWD;
      MODE_INV: op = OP_INV;
      default:  op = OP_PASS;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control: a stage may load when some stage at or after it
  // is empty, or when the output is not stalled.
  // --------------------------------------------------------------------------
  always_comb begin
    logic [NUM_STAGES-1:0] low_mask;
    for (int k = 0; k < NUM_STAGES; k++) begin
      low_mask = (NUM_STAGES'(1) << k) - NUM_STAGES'(1);
      ready[k] = !result_stall || !(&(stage_valid | low_mask));
    end
  end

  assign coeff_stall = !ready[0];

  always_comb begin
    stage_valid_next[0] = ready[0] ? coeff_valid : stage_valid[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      stage_valid_next[k] = ready[k] ? stage_valid[k-1] : stage_valid[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      stage_valid <= stage_valid_next;
    end
  end

  assign result_valid = stage_valid[NUM_STAGES-1];

  // --------------------------------------------------------------------------
  // Input stage: bring every field into [0, q).
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (ready[0]) begin
      a_r  <= red_in(coeff_a);
      b_r  <= red_in(coeff_b);
      c_r  <= red_in(coeff_c);
      d_r  <= red_in(coeff_d);
      t1_r <= red_in(twiddle_1);
      t2_r <= red_in(twiddle_2);
      t3_r <= red_in(twiddle_3);
      t4_r <= red_in(twiddle_4);
    end
  end

  // Second-stage twiddles ride alongside the first butterfly stage.
  always_ff @(posedge clk) begin
    if (ready[1]) begin
      tw3_dly[0] <= t3_r;
      tw4_dly[0] <= t4_r;
    end
    for (int k = 1; k < BFLY_STAGES; k++) begin
      if (ready[k+1]) begin
        tw3_dly[k] <= tw3_dly[k-1];
        tw4_dly[k] <= tw4_dly[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Butterfly stages. In pointwise multiply mode the operands are swapped so
  // that each coefficient passes through exactly one multiplier.
  // --------------------------------------------------------------------------
  assign ctrl1.op = op;
  assign ctrl1.en = ready[BFLY_STAGES:1];
  assign ctrl2.op = op;
  assign ctrl2.en = ready[2*BFLY_STAGES:BFLY_STAGES+1];

  always_comb begin
    if (mode == MODE_MUL) begin
      x1_in = c_r;
      y1_in = a_r;
      x2_in = d_r;
      y2_in = b_r;
    end else begin
      x1_in = a_r;
      y1_in = b_r;
      x2_in = c_r;
      y2_in = d_r;
    end
  end

  ntt2_bfly u_bfly_ab (
    .clk   (clk),
    .ctrl  (ctrl1),
    .x     (x1_in),
    .y     (y1_in),
    .t     (t1_r),
    .x_res (x1_res),
    .y_res (y1_res)
  );

  ntt2_bfly u_bfly_cd (
    .clk   (clk),
    .ctrl  (ctrl1),
    .x     (x2_in),
    .y     (y2_in),
    .t     (t2_r),
    .x_res (x2_res),
    .y_res (y2_res)
  );

  always_comb begin
    if (mode == MODE_MUL) begin
      x3_in = y1_res;
      y3_in = x1_res;
      x4_in = y2_res;
      y4_in = x2_res;
    end else begin
      x3_in = x1_res;
      y3_in = x2_res;
      x4_in = y1_res;
      y4_in = y2_res;
    end
  end

  ntt2_bfly u_bfly_ac (
    .clk   (clk),
    .ctrl  (ctrl2),
    .x     (x3_in),
    .y     (y3_in),
    .t     (tw3_dly[BFLY_STAGES-1]),
    .x_res (x3_res),
    .y_res (y3_res)
  );

  ntt2_bfly u_bfly_bd (
    .clk   (clk),
    .ctrl  (ctrl2),
    .x     (x4_in),
    .y     (y4_in),
    .t     (tw4_dly[BFLY_STAGES-1]),
    .x_res (x4_res),
    .y_res (y4_res)
  );

  always_comb begin
    out_a = x3_res;
    if (mode == MODE_MUL) begin
      out_b = x4_res;
      out_c = y3_res;
    end else begin
      out_b = y3_res;
      out_c = x4_res;
    end
    out_d = y4_res;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `NTT2_ASSERT_SAME(a_result_reduced, result_valid,
    (out_a < MODULUS) && (out_b < MODULUS) && (out_c < MODULUS) && (out_d < MODULUS),
    "result coefficient not reduced below the modulus")
  `NTT2_ASSERT_NEXT(a_accept_loads, coeff_valid && !coeff_stall, stage_valid[0],
    "accepted transfer did not reach the input stage")
  `NTT2_ASSERT_SAME(a_stall_when_full, coeff_stall, (&stage_valid) && result_stall,
    "input stalled while the pipeline still had room")

endmodule

[dv/tb_ntt_2x2_butterfly_mod_q.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ntt_2x2_butterfly_mod_q
// Self-checking bench for the 2x2 butterfly block mod q. A directed table
// of coefficient quads runs first, followed by random quads in every mode
// with random idle cycles on both channels and one long result stall. Each
// result is checked field by field against a table value or a mod-q model.
// ----------------------------------------------------------------------------
module tb_ntt_2x2_butterfly_mod_q
  import ntt2_pkg::*;
();

  typedef logic [COEFF_W-1:0] coeff_t;

  typedef struct packed {
    coeff_t a, b, c, d, t1, t2, t3, t4;
  } quad_in_t;

  typedef struct packed {
    coeff_t a, b, c, d;
  } quad_out_t;

  typedef struct packed {
    logic [1:0] mode;
    quad_in_t   stim;
    logic       typed;
    quad_out_t  want;
  } vec_row_t;

  localparam longint unsigned Q = MODULUS;
  localparam logic [ADDR_W-1:0] ADDR_MODE = {REG_MODE, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_SPARE = {~REG_MODE, 2'b00};
  localparam int ITEMS_PER_SEG = 38;
  localparam int LONG_HOLD = 80;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               coeff_valid = 1'b0;
  logic               coeff_stall;
  coeff_t             coeff_a = '0, coeff_b = '0, coeff_c = '0, coeff_d = '0;
  coeff_t             twiddle_1 = '0, twiddle_2 = '0, twiddle_3 = '0, twiddle_4 = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  coeff_t             out_a, out_b, out_c, out_d;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  quad_out_t  pending_quads[$];
  vec_row_t   dir_rows[$];
  logic [1:0] mode_shadow = MODE_FWD;
  int         n_errs = 0;
  int         send_idle_pct = 31;
  int         recv_idle_pct = 78;
  int         hold_ask = 0;
  int         hold_seen = 0;
  int         hold_left = 0;

  ntt_2x2_butterfly_mod_q uut (
    .clk         (clk),
    .rst         (rst),
    .coeff_valid (coeff_valid),
    .coeff_stall (coeff_stall),
    .coeff_a     (coeff_a),
    .coeff_b     (coeff_b),
    .coeff_c     (coeff_c),
    .coeff_d     (coeff_d),
    .twiddle_1   (twiddle_1),
    .twiddle_2   (twiddle_2),
    .twiddle_3   (twiddle_3),
    .twiddle_4   (twiddle_4),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .out_a       (out_a),
    .out_b       (out_b),
    .out_c       (out_c),
    .out_d       (out_d),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    $display("ERROR @%0t: %s", $time, what);
    n_errs++;
  endtask

  // ---------------- mod-q butterfly model ----------------

  function automatic coeff_t canon(input logic [63:0] v);
    return coeff_t'(v % Q);
  endfunction

  function automatic coeff_t mul_q(input coeff_t x, input coeff_t y);
    return canon(64'(x) * 64'(y));
  endfunction

  function automatic coeff_t add_q(input coeff_t x, input coeff_t y);
    return canon(64'(x) + 64'(y));
  endfunction

  function automatic coeff_t sub_q(input coeff_t x, input coeff_t y);
    return canon(64'(x) + Q - 64'(y));
  endfunction

  // An odd residue plus q is even and below 2q, so one shift halves it.
  function automatic coeff_t half_q(input coeff_t x);
    logic [63:0] v;
    v = x[0] ? 64'(x) + Q : 64'(x);
    return coeff_t'(v >> 1);
  endfunction

  function automatic void butterfly(input logic [1:0] m, input coeff_t x, input coeff_t y,
                                    input coeff_t t, output coeff_t hi, output coeff_t lo);
    case (m)
      MODE_FWD: begin
        hi = add_q(x, mul_q(t, y));
        lo = sub_q(x, mul_q(t, y));
      end
      MODE_INV: begin
        hi = half_q(add_q(x, y));
        lo = half_q(mul_q(t, sub_q(x, y)));
      end
      default: begin
        hi = x;
        lo = mul_q(t, y);
      end
    endcase
  endfunction

  function automatic quad_out_t ntt_quad_result(input logic [1:0] m, input quad_in_t q);
    coeff_t a, b, c, d, t1, t2, t3, t4, a1, b1, c1, d1;
    quad_out_t r;
    a  = canon(64'(q.a));
    b  = canon(64'(q.b));
    c  = canon(64'(q.c));
    d  = canon(64'(q.d));
    t1 = canon(64'(q.t1));
    t2 = canon(64'(q.t2));
    t3 = canon(64'(q.t3));
    t4 = canon(64'(q.t4));
    if (m == MODE_MUL) begin
      r.a = mul_q(t1, a);
      r.b = mul_q(t2, b);
      r.c = mul_q(t3, c);
      r.d = mul_q(t4, d);
    end else begin
      butterfly(m, a, b, t1, a1, b1);
      butterfly(m, c, d, t2, c1, d1);
      butterfly(m, a1, c1, t3, r.a, r.b);
      butterfly(m, b1, d1, t4, r.c, r.d);
    end
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic coeff_t rand_coeff();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return coeff_t'(Q - 1);
      2: return coeff_t'($urandom_range(int'(Q), 23'h7FFFFF));
      3: return coeff_t'(1);
      default: return coeff_t'($urandom_range(0, int'(Q) - 1));
    endcase
  endfunction

  function automatic quad_in_t rand_quad();
    quad_in_t q;
    q = {rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff(),
         rand_coeff(), rand_coeff(), rand_coeff(), rand_coeff()};
    return q;
  endfunction

  task automatic add_row(input logic [1:0] m, input int a, input int b, input int c,
                         input int d, input int t1, input int t2, input int t3,
                         input int t4, input logic typed, input int ea, input int eb,
                         input int ec, input int ed);
    vec_row_t row;
    row.mode  = m;
    row.stim  = {coeff_t'(a), coeff_t'(b), coeff_t'(c), coeff_t'(d),
                 coeff_t'(t1), coeff_t'(t2), coeff_t'(t3), coeff_t'(t4)};
    row.typed = typed;
    row.want  = {coeff_t'(ea), coeff_t'(eb), coeff_t'(ec), coeff_t'(ed)};
    dir_rows.push_back(row);
  endtask

  // Each call starts at a rising edge; the transfer happens at the edge
  // on which the task returns.
  task automatic offer_quad(input quad_in_t q, input logic typed, input quad_out_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      coeff_valid <= 1'b0;
      @(posedge clk);
    end
    {coeff_a, coeff_b, coeff_c, coeff_d, twiddle_1, twiddle_2, twiddle_3, twiddle_4} <= q;
    coeff_valid <= 1'b1;
    @(posedge clk);
    while (coeff_stall) @(posedge clk);
    pending_quads.push_back(typed ? want : ntt_quad_result(mode_shadow, q));
  endtask

  task automatic drain();
    coeff_valid <= 1'b0;
    while (pending_quads.size() != 0) @(posedge clk);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr[2] == REG_MODE) mode_shadow = data[1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_mode_readback();
    logic [DATA_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_MODE;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== DATA_W'(mode_shadow))
      flag_mismatch($sformatf("mode readback got %0d expected %0d", got, mode_shadow));
  endtask

  // ---------------- result side ----------------

  always @(posedge clk) begin : result_check
    quad_out_t got;
    quad_out_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        got = {out_a, out_b, out_c, out_d};
        if (pending_quads.size() == 0) begin
          flag_mismatch("result transfer with no quad pending");
        end else begin
          want = pending_quads.pop_front();
          for (int i = 0; i < 4; i++) begin
            if (got[(3-i)*COEFF_W +: COEFF_W] !== want[(3-i)*COEFF_W +: COEFF_W])
              flag_mismatch($sformatf("out_%c got %0d expected %0d", 8'(97 + i),
                                      got[(3-i)*COEFF_W +: COEFF_W],
                                      want[(3-i)*COEFF_W +: COEFF_W]));
          end
        end
      end
      if (hold_seen != hold_ask) begin
        hold_seen = hold_ask;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else begin
        result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // ---------------- main sequence ----------------

  initial begin : stimulus
    logic [1:0] mode_order[4];
    int send_pct[3];
    int recv_pct[3];
    mode_order = '{MODE_FWD, MODE_INV, MODE_MUL, MODE_PASS};
    send_pct   = '{31, 78, 0};
    recv_pct   = '{78, 31, 0};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_mode_readback();

    // Forward: zero twiddles copy a everywhere; unit inputs give 4,0,0,0.
    add_row(MODE_FWD, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 0, 0, 0, 0);
    add_row(MODE_FWD, 5, 0, 0, 0, 0, 0, 0, 0, 1'b1, 5, 5, 5, 5);
    add_row(MODE_FWD, 1, 1, 1, 1, 1, 1, 1, 1, 1'b1, 4, 0, 0, 0);
    add_row(MODE_FWD, 8380416, 8380416, 8380416, 8380416,
            8380416, 8380416, 8380416, 8380416, 1'b0, 0, 0, 0, 0);
    add_row(MODE_FWD, 8388607, 8388607, 8388607, 8388607,
            8388607, 8388607, 8388607, 8388607, 1'b0, 0, 0, 0, 0);
    add_row(MODE_FWD, 1234567, 7654321, 42, 8380000, 1753, 3073009, 2, 8380415,
            1'b0, 0, 0, 0, 0);
    // Inverse: a lone one, unit twiddles: a quarter, 6285313, in every slot.
    add_row(MODE_INV, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 0, 0, 0, 0);
    add_row(MODE_INV, 1, 0, 0, 0, 1, 1, 1, 1, 1'b1, 6285313, 6285313, 6285313, 6285313);
    add_row(MODE_INV, 0, 1, 0, 0, 0, 0, 0, 0, 1'b1, 6285313, 0, 0, 0);
    add_row(MODE_INV, 8380416, 8380416, 8380416, 8380416,
            8380416, 8380416, 8380416, 8380416, 1'b0, 0, 0, 0, 0);
    add_row(MODE_INV, 8388607, 8380417, 8388607, 8380417,
            8388607, 8380417, 8388607, 8380417, 1'b0, 0, 0, 0, 0);
    // Multiply: (q-1)^2 is one; an unreduced all-ones input reduces to 8190.
    add_row(MODE_MUL, 8380416, 8380416, 8380416, 8380416,
            8380416, 8380416, 8380416, 8380416, 1'b1, 1, 1, 1, 1);
    add_row(MODE_MUL, 8388607, 8388607, 8388607, 8388607, 1, 1, 1, 1,
            1'b1, 8190, 8190, 8190, 8190);
    add_row(MODE_MUL, 123, 456, 789, 1011, 0, 0, 0, 0, 1'b1, 0, 0, 0, 0);
    add_row(MODE_MUL, 8388607, 77, 4190208, 3, 2, 8388607, 8380417, 4190209,
            1'b0, 0, 0, 0, 0);
    // Mode three passes x through, so unit twiddles swap b and c.
    add_row(MODE_PASS, 11, 22, 33, 44, 1, 1, 1, 1, 1'b1, 11, 33, 22, 44);
    add_row(MODE_PASS, 8380416, 8380416, 8380416, 8380416,
            8380416, 8380416, 8380416, 8380416, 1'b0, 0, 0, 0, 0);
    add_row(MODE_PASS, 8388607, 8388607, 8388607, 8388607,
            8388607, 8388607, 8388607, 8388607, 1'b0, 0, 0, 0, 0);

    send_idle_pct <= send_pct[0];
    recv_idle_pct <= recv_pct[0];
    foreach (dir_rows[i]) begin
      if (dir_rows[i].mode != mode_shadow) begin
        drain();
        apb_write(ADDR_MODE, (DATA_W'($urandom()) & ~DATA_W'(3)) | DATA_W'(dir_rows[i].mode));
        check_mode_readback();
      end
      offer_quad(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
    end

    // A write to the unused word must leave the mode alone.
    drain();
    apb_write(ADDR_SPARE, DATA_W'($urandom()));
    check_mode_readback();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct <= send_pct[ph];
      recv_idle_pct <= recv_pct[ph];
      for (int seg = 0; seg < 4; seg++) begin
        drain();
        apb_write(ADDR_MODE, (DATA_W'($urandom()) & ~DATA_W'(3)) |
                             DATA_W'(mode_order[(seg + ph) % 4]));
        check_mode_readback();
        // With no idling on the input side a long result stall fills the
        // pipeline and pushes back on coefficient transfers.
        if (ph == 2 && seg == 0) hold_ask <= hold_ask + 1;
        repeat (ITEMS_PER_SEG) offer_quad(rand_quad(), 1'b0, '0);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (n_errs == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/ntt2_pkg.sv
rtl/core/ntt2_bfly.sv
rtl/core/ntt_2x2_butterfly_mod_q.sv
dv/tb_ntt_2x2_butterfly_mod_q.sv
